### hdl/assert_macros.svh
// Assertion macros shared by the segmenter modules.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define VRGSEG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define VRGSEG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/vrgseg_pkg.sv
// Shared widths, constants, register indexes and types of the segmenter.
// Depends on nothing; every other file but assert_macros.svh imports it.
package vrgseg_pkg;

	localparam int WL_W   = 32;
	localparam int REG_W  = 26;
	localparam int PROD_W = 62;
	localparam int TWO_C_W = 30;

	// Twice the speed of light in m/s.
	localparam logic [TWO_C_W-1:0] TWO_C_MPS = 30'd599584916;

	// Configuration register indexes.
	localparam logic [0:0] REG_MAX_GAP    = 1'b0;
	localparam logic [0:0] REG_MIN_REGION = 1'b1;

	typedef struct packed {
		logic [WL_W-1:0] wavelength;
		logic            pixel_valid;
		logic            last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [WL_W-1:0] region_start;
		logic [WL_W-1:0] region_end;
		logic            at_spectrum_end;
	} region_t;

	typedef struct packed {
		logic    valid;
		region_t data;
	} result_t;

endpackage

### hdl/vrgseg_in_if.sv
// Pixel channel of the segmenter: valid/ready handshake with the pixel fields.
// Depends on vrgseg_pkg for the field widths.
interface vrgseg_in_if;
	import vrgseg_pkg::*;

	logic            valid;
	logic            ready;
	logic [WL_W-1:0] wavelength;
	logic            pixel_valid;
	logic            last_pixel;

	modport source (output valid, output wavelength, output pixel_valid,
		output last_pixel, input ready);
	modport sink (input valid, input wavelength, input pixel_valid,
		input last_pixel, output ready);

endinterface

### hdl/vrgseg_out_if.sv
// Region channel of the segmenter: valid/ready handshake with the region fields.
// Depends on vrgseg_pkg for the field widths.
interface vrgseg_out_if;
	import vrgseg_pkg::*;

	logic            valid;
	logic            ready;
	logic [WL_W-1:0] region_start;
	logic [WL_W-1:0] region_end;
	logic            at_spectrum_end;

	modport source (output valid, output region_start, output region_end,
		output at_spectrum_end, input ready);
	modport sink (input valid, input region_start, input region_end,
		input at_spectrum_end, output ready);

endinterface

### hdl/vrgseg_vcmp.sv
// Division-free velocity compare: 2c*(hi-lo) <= coef*(hi+lo).
// Depends on vrgseg_pkg.
module vrgseg_vcmp (
	input  logic [vrgseg_pkg::WL_W-1:0]  lo,
	input  logic [vrgseg_pkg::WL_W-1:0]  hi,
	input  logic [vrgseg_pkg::REG_W-1:0] coef,
	output logic                         hi_below_lo,
	output logic                         prod_le
);
	import vrgseg_pkg::*;

	logic [WL_W-1:0]   diff;
	logic [WL_W:0]     sum;
	logic [PROD_W-1:0] lhs;
	logic [PROD_W-1:0] rhs;

	assign hi_below_lo = hi < lo;
	assign diff = hi - lo;
	assign sum  = {1'b0, hi} + {1'b0, lo};
	assign lhs  = PROD_W'(TWO_C_MPS) * PROD_W'(diff);
	assign rhs  = PROD_W'(coef) * PROD_W'(sum);
	assign prod_le = lhs <= rhs;

endmodule

### hdl/vrgseg_core.sv
// Region state, configuration registers and per-pixel merge decision.
// Depends on vrgseg_pkg, vrgseg_vcmp and assert_macros.svh.
module vrgseg_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_en,
	input  logic [0:0]                   cfg_index,
	input  logic [vrgseg_pkg::REG_W-1:0] cfg_data,
	input  logic                         take,
	input  vrgseg_pkg::pixel_t           pix,
	output vrgseg_pkg::result_t          res
);
	import vrgseg_pkg::*;
	`include "assert_macros.svh"

	logic [REG_W-1:0] max_gap_q;
	logic [REG_W-1:0] min_region_q;

	logic            region_open_q;
	logic [WL_W-1:0] open_start_q;
	logic [WL_W-1:0] open_end_q;
	logic [WL_W-1:0] prev_wl_q;
	logic            prev_valid_q;

	logic gap_below, gap_le, bridged;
	logic ext_below, ext_le, wide_ext;
	logic cur_below, cur_le, wide_cur;

	logic            open_nx;
	logic [WL_W-1:0] start_nx;
	logic [WL_W-1:0] end_nx;
	logic            wide_nx;
	logic            gap_emit;
	result_t         res_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q    <= '0;
			min_region_q <= '0;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_MAX_GAP:    max_gap_q    <= cfg_data;
				REG_MIN_REGION: min_region_q <= cfg_data;
			endcase
		end
	end

	// Gap from the end of the open region to the last invalid pixel.
	vrgseg_vcmp u_gap (
		.lo          (open_end_q),
		.hi          (prev_wl_q),
		.coef        (max_gap_q),
		.hi_below_lo (gap_below),
		.prod_le     (gap_le)
	);

	// Width of the open region if this pixel extends it.
	vrgseg_vcmp u_ext (
		.lo          (open_start_q),
		.hi          (pix.wavelength),
		.coef        (min_region_q),
		.hi_below_lo (ext_below),
		.prod_le     (ext_le)
	);

	// Width of the open region as it stands, against the current floor.
	vrgseg_vcmp u_cur (
		.lo          (open_start_q),
		.hi          (open_end_q),
		.coef        (min_region_q),
		.hi_below_lo (cur_below),
		.prod_le     (cur_le)
	);

	assign bridged  = gap_below | gap_le;
	assign wide_ext = !ext_below && !ext_le;
	assign wide_cur = !cur_below && !cur_le;

	always_comb begin
		open_nx  = region_open_q;
		start_nx = open_start_q;
		end_nx   = open_end_q;
		wide_nx  = wide_cur;
		gap_emit = 1'b0;
		res_nx   = '0;
		if (pix.pixel_valid) begin
			if (region_open_q && (prev_valid_q || bridged)) begin
				end_nx  = pix.wavelength;
				wide_nx = wide_ext;
			end else begin
				// Either the first run or a gap too large to bridge.
				gap_emit = region_open_q && wide_cur;
				open_nx  = 1'b1;
				start_nx = pix.wavelength;
				end_nx   = pix.wavelength;
				wide_nx  = 1'b0;
			end
		end
		if (gap_emit) begin
			res_nx.valid                = 1'b1;
			res_nx.data.region_start    = open_start_q;
			res_nx.data.region_end      = open_end_q;
			res_nx.data.at_spectrum_end = 1'b0;
		end else if (pix.last_pixel && open_nx && wide_nx) begin
			res_nx.valid                = 1'b1;
			res_nx.data.region_start    = start_nx;
			res_nx.data.region_end      = end_nx;
			res_nx.data.at_spectrum_end = 1'b1;
		end
		res_nx.valid = res_nx.valid && take;
	end

	assign res = res_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_open_q <= 1'b0;
			open_start_q  <= '0;
			open_end_q    <= '0;
			prev_wl_q     <= '0;
			prev_valid_q  <= 1'b0;
		end else if (take) begin
			if (pix.last_pixel) begin
				region_open_q <= 1'b0;
				open_start_q  <= '0;
				open_end_q    <= '0;
				prev_wl_q     <= '0;
				prev_valid_q  <= 1'b0;
			end else begin
				region_open_q <= open_nx;
				open_start_q  <= start_nx;
				open_end_q    <= end_nx;
				prev_wl_q     <= pix.wavelength;
				prev_valid_q  <= pix.pixel_valid;
			end
		end
	end

	`VRGSEG_ASSERT(a_closed_idle, !region_open_q |-> (open_start_q == '0 && open_end_q == '0), "region bounds set with no open region")
	`VRGSEG_ASSERT(a_res_needs_take, res.valid |-> take, "region word without an accepted pixel")
	`VRGSEG_ASSERT(a_last_clears, (take && pix.last_pixel) |=> (!region_open_q && !prev_valid_q), "state not cleared after last pixel")

endmodule

### hdl/vrgseg_obuf.sv
// Output register with a one-word skid stage for the region channel.
// Depends on vrgseg_pkg, vrgseg_out_if and assert_macros.svh.
module vrgseg_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  vrgseg_pkg::result_t res,
	output logic                full,
	vrgseg_out_if.source        regions
);
	import vrgseg_pkg::*;
	`include "assert_macros.svh"

	logic    out_valid_q;
	logic    skid_valid_q;
	region_t out_q;
	region_t skid_q;
	logic    out_ready;
	logic    load_out;
	logic    load_skid;

	assign out_ready = regions.ready;
	assign full      = skid_valid_q;

	assign load_out  = skid_valid_q ? out_ready : (res.valid && (!out_valid_q || out_ready));
	assign load_skid = !skid_valid_q && res.valid && out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_ready) begin
					skid_valid_q <= 1'b0;
				end
			end else if (res.valid) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= out_valid_q && !out_ready;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : res.data;
		end
		if (load_skid) begin
			skid_q <= res.data;
		end
	end

	assign regions.valid           = out_valid_q;
	assign regions.region_start    = out_q.region_start;
	assign regions.region_end      = out_q.region_end;
	assign regions.at_spectrum_end = out_q.at_spectrum_end;

	`VRGSEG_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid word held with empty output register")
	`VRGSEG_ASSERT(a_no_drop, res.valid |-> !skid_valid_q, "result arrived while skid stage full")
	`VRGSEG_ASSERT(a_skid_moves, (skid_valid_q && out_ready) |=> (out_q == $past(skid_q)), "skid word not moved to output")

endmodule

### hdl/valid_run_gap_bridging_segmenter.sv
// A region word is registered when the pixel that closes it is taken.
// Throughput: one pixel word per cycle while pixel ready is high; a word is accepted
// while a region word waits. Ready drops only when output and skid registers are full.
// Reset (arst_n low, asynchronous) clears region state, handshake state and both
// configuration registers to zero; there is no clearing pass.
module valid_run_gap_bridging_segmenter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_en,
	input  logic [0:0]                   cfg_index,
	input  logic [vrgseg_pkg::REG_W-1:0] cfg_data,
	vrgseg_in_if.sink                    pixels,
	vrgseg_out_if.source                 regions
);
	import vrgseg_pkg::*;

	// The whole merge decision for a pixel is made combinationally in the core: three
	// velocity compares run side by side, one on the gap in front of the pixel, one
	// on the width the open region would have if the pixel extends it, and one on
	// the width of the open region as it stands. Widths are always taken against the
	// current floor, so a region closed later by a large gap is judged correctly even
	// when the floor was rewritten while it was open.
	pixel_t  pix;
	result_t res;
	logic    take;
	logic    full;

	assign pixels.ready = !full;
	// A pixel word is taken on every edge where valid and ready meet.
	assign take = pixels.valid && pixels.ready;

	assign pix.wavelength  = pixels.wavelength;
	assign pix.pixel_valid = pixels.pixel_valid;
	assign pix.last_pixel  = pixels.last_pixel;

	vrgseg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.pix       (pix),
		.res       (res)
	);

	// The output register and skid stage separate the two channels, so the pixel
	// side keeps flowing while one region word waits to be taken.
	vrgseg_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.res     (res),
		.full    (full),
		.regions (regions)
	);

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of valid_run_gap_bridging_segmenter: directed and random pixel words
// go in, a built-in region predictor fills a queue that the region channel is checked against.
// Depends on vrgseg_pkg, the interfaces vrgseg_in_if and vrgseg_out_if, and the segmenter RTL.
module tb_top;
	import vrgseg_pkg::*;

	// Random part: pixel word count and the pixel words per register setting.
	localparam int PIXEL_TARGET = 1550;
	localparam int PHASE_LEN    = 160;
	// The last pixel words of the run go through with no idling on either side.
	localparam int QUIET_TAIL   = 200;
	// Settle time of the drain, for pixel words that close nothing to pass through the block.
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_MAX   = 10;
	localparam logic [REG_W-1:0] REG_TOP = '1;

	logic             clk;
	logic             arst_n;
	logic             cfg_en;
	logic [0:0]       cfg_index;
	logic [REG_W-1:0] cfg_data;

	vrgseg_in_if  pix_if();
	vrgseg_out_if reg_if();

	valid_run_gap_bridging_segmenter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix_if),
		.regions   (reg_if)
	);

	// Predictor copy of the two limits and of the open region.
	logic [REG_W-1:0] max_gap;
	logic [REG_W-1:0] min_width;
	logic             seg_open;
	logic [WL_W-1:0]  seg_start;
	logic [WL_W-1:0]  seg_end;
	logic [WL_W-1:0]  last_wl;
	logic             last_was_valid;

	// Regions that accepted pixel words have closed and that the block still owes.
	region_t pending_regions[$];

	int err_count;
	int pixels_sent;
	int cycle_count;
	bit idle_on;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("watchdog: no progress after %0d cycles, %0d regions still owed",
				cycle_count, pending_regions.size());
			$display("tb_top: errors");
			$finish;
		end
	end

	// Velocity compares done as exact 64-bit products, 2c*(b - a) against limit*(b + a).
	// A gap that runs backward in wavelength always counts as bridged.
	function automatic bit gap_is_bridged(input logic [WL_W-1:0] a, input logic [WL_W-1:0] b);
		logic [63:0] lhs;
		logic [63:0] rhs;
		if (b < a)
			return 1'b1;
		lhs = 64'(TWO_C_MPS) * 64'(b - a);
		rhs = 64'(max_gap) * (64'(a) + 64'(b));
		return lhs <= rhs;
	endfunction

	// A region whose end lies below its start has negative width and never passes.
	function automatic bit region_is_wide(input logic [WL_W-1:0] s, input logic [WL_W-1:0] e);
		logic [63:0] lhs;
		logic [63:0] rhs;
		if (e < s)
			return 1'b0;
		lhs = 64'(TWO_C_MPS) * 64'(e - s);
		rhs = 64'(min_width) * (64'(s) + 64'(e));
		return lhs > rhs;
	endfunction

	function automatic void clear_segment();
		seg_open       = 1'b0;
		seg_start      = '0;
		seg_end        = '0;
		last_wl        = '0;
		last_was_valid = 1'b0;
	endfunction

	// Advances the predicted segmenter state by one accepted pixel word and queues the
	// region it closes, if any. A gap close and an end-of-spectrum close never both emit.
	function automatic void segment_pixel(input pixel_t px);
		region_t closed;
		bit      emitted;
		closed  = '0;
		emitted = 1'b0;
		if (px.pixel_valid) begin
			if (seg_open && last_was_valid) begin
				seg_end = px.wavelength;
			end else if (seg_open) begin
				// A new run starts: bridge the gap or close the open region.
				if (gap_is_bridged(seg_end, last_wl)) begin
					seg_end = px.wavelength;
				end else begin
					if (region_is_wide(seg_start, seg_end)) begin
						closed  = '{region_start: seg_start, region_end: seg_end,
							at_spectrum_end: 1'b0};
						emitted = 1'b1;
					end
					seg_start = px.wavelength;
					seg_end   = px.wavelength;
				end
			end else begin
				seg_open  = 1'b1;
				seg_start = px.wavelength;
				seg_end   = px.wavelength;
			end
		end
		last_wl        = px.wavelength;
		last_was_valid = px.pixel_valid;
		if (px.last_pixel) begin
			if (seg_open && !emitted && region_is_wide(seg_start, seg_end)) begin
				closed  = '{region_start: seg_start, region_end: seg_end, at_spectrum_end: 1'b1};
				emitted = 1'b1;
			end
			clear_segment();
		end
		if (emitted)
			pending_regions.push_back(closed);
	endfunction

	// Offers one pixel word and returns at the edge that accepts it. Valid stays high into
	// the next call, so it is only lowered here when an idle burst is about to start.
	task automatic send_pixel(input logic [WL_W-1:0] wl, input logic valid_flag,
		input logic last_flag);
		pixel_t px;
		px = '{wavelength: wl, pixel_valid: valid_flag, last_pixel: last_flag};
		if (idle_on && $urandom_range(0, 3) == 0) begin
			pix_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		pix_if.valid       <= 1'b1;
		pix_if.wavelength  <= px.wavelength;
		pix_if.pixel_valid <= px.pixel_valid;
		pix_if.last_pixel  <= px.last_pixel;
		do
			@(posedge clk);
		while (pix_if.ready !== 1'b1);
		pixels_sent++;
		segment_pixel(px);
	endtask

	// Stops the pixel stream and waits until every owed region word has been taken,
	// then lets the last pixel words that close nothing work through the block.
	task automatic drain();
		pix_if.valid <= 1'b0;
		while (pending_regions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the gap register, then the width register; only called while the block is idle.
	task automatic set_limits(input logic [REG_W-1:0] gap_mps, input logic [REG_W-1:0] width_mps);
		cfg_en    <= 1'b1;
		cfg_index <= REG_MAX_GAP;
		cfg_data  <= gap_mps;
		@(posedge clk);
		max_gap = gap_mps;
		cfg_index <= REG_MIN_REGION;
		cfg_data  <= width_mps;
		@(posedge clk);
		min_width = width_mps;
		cfg_en <= 1'b0;
		@(posedge clk);
	endtask

	// Limits spread over many decades, from zero up to the full register.
	function automatic logic [REG_W-1:0] random_limit();
		return REG_W'($urandom_range(0, 32'(REG_TOP)) >> $urandom_range(0, 20));
	endfunction

	// Both limits still at their reset value of zero.
	task automatic test_reset_defaults();
		// Zero wavelengths: the gap compare reads 0 <= 0 and bridges; the zero-width
		// region that results is dropped at the end of the spectrum.
		send_pixel(32'd0, 1'b1, 1'b0);
		send_pixel(32'd0, 1'b1, 1'b0);
		send_pixel(32'd0, 1'b0, 1'b0);
		send_pixel(32'd0, 1'b1, 1'b1);
		// A spectrum with no valid pixel emits nothing.
		send_pixel(32'd100, 1'b0, 1'b0);
		send_pixel(32'd200, 1'b0, 1'b1);
		// Any positive width passes a zero minimum.
		send_pixel(32'd1000, 1'b1, 1'b0);
		send_pixel(32'd2000, 1'b1, 1'b1);
	endtask

	// Widest bridging, no width floor.
	task automatic test_gap_bridging();
		drain();
		set_limits(REG_TOP, '0);
		// Descending wavelengths: the backward gap bridges, and the region ends below its
		// start, so it is never emitted.
		send_pixel(32'd5000, 1'b1, 1'b0);
		send_pixel(32'd4000, 1'b0, 1'b0);
		send_pixel(32'd3000, 1'b1, 1'b0);
		send_pixel(32'd2000, 1'b1, 1'b1);
		// Gap close on the final pixel: the open region goes out with the end flag clear,
		// the single-pixel region left behind is dropped.
		send_pixel(32'd1000, 1'b1, 1'b0);
		send_pixel(32'd1100, 1'b1, 1'b0);
		send_pixel(32'd5000, 1'b0, 1'b0);
		send_pixel(32'd90000, 1'b1, 1'b1);
		// Full wavelength range in one region.
		send_pixel(32'h0000_0000, 1'b1, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b1, 1'b1);
	endtask

	// No bridging beyond equal wavelengths, highest width floor.
	task automatic test_region_width();
		drain();
		set_limits('0, REG_TOP);
		// Equal wavelengths still bridge at a zero limit; this region is too narrow.
		send_pixel(32'd1000, 1'b1, 1'b0);
		send_pixel(32'd1000, 1'b0, 1'b0);
		send_pixel(32'd1200, 1'b1, 1'b1);
		// Wide enough to pass the highest floor.
		send_pixel(32'd1000, 1'b1, 1'b0);
		send_pixel(32'd2000, 1'b1, 1'b1);
	endtask

	// One well-formed spectrum: ascending wavelengths with a random pixel pitch, runs of
	// valid and invalid pixels, and last_pixel on the final word. The pitch sets the
	// velocity per pixel between a few km/s and tens of thousands of km/s, so gaps and
	// widths land on both sides of the limits. Now and then the wavelength steps back.
	task automatic send_spectrum();
		logic [WL_W-1:0] wl;
		logic [WL_W-1:0] pitch;
		int              len;
		int              run_left;
		logic            cur_valid;
		len       = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(2, 14);
		wl        = $urandom_range(32'h0000_0400, 32'hF000_0000);
		pitch     = (wl >> $urandom_range(3, 16)) + 1;
		cur_valid = $urandom_range(0, 1);
		run_left  = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			send_pixel(wl, cur_valid, i == len - 1);
			if ($urandom_range(0, 24) == 0)
				wl = wl - $urandom_range(0, pitch);
			else
				wl = wl + $urandom_range(0, 2 * pitch);
			run_left--;
			if (run_left == 0) begin
				cur_valid = !cur_valid;
				run_left  = cur_valid ? $urandom_range(1, 6) : $urandom_range(1, 4);
			end
		end
	endtask

	// Register settings change after at least PHASE_LEN pixel words: the four corners first, then
	// random limits. Spectra are mixed with short bursts of unrelated pixel words that
	// break the sequence and leave regions open across spectrum boundaries.
	task automatic test_random_spectra();
		int phase;
		int phase_end;
		phase     = 0;
		phase_end = 0;
		while (pixels_sent < PIXEL_TARGET) begin
			if (pixels_sent >= phase_end) begin
				// The sender holds off here until every owed region word is in.
				drain();
				case (phase)
					0:       set_limits('0, '0);
					1:       set_limits(REG_TOP, REG_TOP);
					2:       set_limits('0, REG_TOP);
					3:       set_limits(REG_TOP, '0);
					default: set_limits(random_limit(), random_limit());
				endcase
				phase++;
				phase_end = pixels_sent + PHASE_LEN;
				idle_on   = ($urandom_range(0, 3) != 0);
			end
			if (pixels_sent >= PIXEL_TARGET - QUIET_TAIL)
				idle_on = 1'b0;
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 5))
					send_pixel($urandom, 1'($urandom), $urandom_range(0, 7) == 0);
			end else begin
				send_spectrum();
			end
		end
	endtask

	// Region side: takes region words with random stall bursts and checks each one
	// against the oldest owed region, field by field.
	initial begin : region_check
		int      stall_left;
		region_t want;
		stall_left = 0;
		reg_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (reg_if.valid === 1'b1 && reg_if.ready === 1'b1) begin
				if (pending_regions.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_MAX)
						$display("unexpected region word: start %h end %h at_end %b",
							reg_if.region_start, reg_if.region_end, reg_if.at_spectrum_end);
				end else begin
					want = pending_regions.pop_front();
					if (reg_if.region_start !== want.region_start ||
						reg_if.region_end !== want.region_end ||
						reg_if.at_spectrum_end !== want.at_spectrum_end) begin
						err_count++;
						if (err_count <= REPORT_MAX)
							$display({"region mismatch: expected start %h end %h at_end %b, ",
								"got start %h end %h at_end %b"},
								want.region_start, want.region_end, want.at_spectrum_end,
								reg_if.region_start, reg_if.region_end,
								reg_if.at_spectrum_end);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				reg_if.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 9);
				reg_if.ready <= 1'b0;
			end else begin
				reg_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n             <= 1'b0;
		cfg_en             <= 1'b0;
		cfg_index          <= REG_MAX_GAP;
		cfg_data           <= '0;
		pix_if.valid       <= 1'b0;
		pix_if.wavelength  <= '0;
		pix_if.pixel_valid <= 1'b0;
		pix_if.last_pixel  <= 1'b0;
		err_count    = 0;
		pixels_sent  = 0;
		cycle_count  = 0;
		idle_on      = 1'b1;
		max_gap      = '0;
		min_width    = '0;
		clear_segment();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_gap_bridging();
		test_region_width();
		test_random_spectra();

		drain();
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
